// ----- hw/rtl/whitespace_tolerant_word_locator_assert.svh -----
// Assertion macros shared by the word locator RTL.
`ifndef WHITESPACE_TOLERANT_WORD_LOCATOR_ASSERT_SVH
`define WHITESPACE_TOLERANT_WORD_LOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define WTWL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define WTWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/wtwl_pkg.sv -----
// Shared constants for the whitespace tolerant word locator.
`timescale 1ns / 1ps
`default_nettype none
package wtwl_pkg;

  localparam int MAX_PATTERN_DEFAULT   = 8;
  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH           = 4;

  localparam int CHAR_W    = 8;
  localparam int PATTERN_W = 64;
  localparam int LENGTH_W  = 4;
  localparam int RESULT_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CHARS  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

endpackage
`default_nettype wire

// ----- hw/rtl/wtwl_front.sv -----
// Front end: takes text bytes, tracks line and column, forwards every byte other than tab, space and line feed.
`timescale 1ns / 1ps
`default_nettype none
module wtwl_front #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          text_valid,
  output logic                               text_stall,
  input  wire logic [wtwl_pkg::CHAR_W-1:0]   text_byte,
  input  wire logic                          first_of_file,
  input  wire logic                          queue_full,
  output logic                               push,
  output logic                               push_clear,
  output logic [wtwl_pkg::CHAR_W-1:0]        push_char,
  output logic [POSITION_BITS-1:0]           push_line,
  output logic [POSITION_BITS-1:0]           push_column
);
  import wtwl_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [POSITION_BITS-1:0] line, line_next;
  logic [POSITION_BITS-1:0] column, column_next;
  logic                     pending_clear, pending_clear_next;

  logic                     take;
  logic                     is_lf, is_blank;
  logic [POSITION_BITS-1:0] base_line, base_column, line_inc, column_inc;

  assign text_stall = queue_full;

  always_comb begin
    take        = text_valid && !queue_full;
    is_lf       = (text_byte == CH_LF);
    is_blank    = (text_byte == CH_TAB) || (text_byte == CH_SPACE);
    base_line   = first_of_file ? POS_ONE : line;
    base_column = first_of_file ? POS_ONE : column;
    line_inc    = (base_line == POS_MAX) ? base_line : base_line + POS_ONE;
    column_inc  = (base_column == POS_MAX) ? base_column : base_column + POS_ONE;

    line_next          = line;
    column_next        = column;
    pending_clear_next = pending_clear;
    push               = 1'b0;

    if (take) begin
      if (is_lf) begin
        line_next          = line_inc;
        column_next        = POS_ONE;
        pending_clear_next = pending_clear | first_of_file;
      end else if (is_blank) begin
        line_next          = base_line;
        column_next        = column_inc;
        pending_clear_next = pending_clear | first_of_file;
      end else begin
        // A restart seen on a skipped byte is carried to the next stored character.
        line_next          = base_line;
        column_next        = column_inc;
        pending_clear_next = 1'b0;
        push               = 1'b1;
      end
    end
  end

  assign push_clear  = pending_clear | first_of_file;
  assign push_char   = text_byte;
  assign push_line   = base_line;
  assign push_column = base_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      line          <= POS_ONE;
      column        <= POS_ONE;
      pending_clear <= 1'b0;
    end else begin
      line          <= line_next;
      column        <= column_next;
      pending_clear <= pending_clear_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/wtwl_queue.sv -----
// Short register queue between the front end and the matcher.
`timescale 1ns / 1ps
`default_nettype none
`include "whitespace_tolerant_word_locator_assert.svh"
module wtwl_queue #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(DEPTH);

  logic [WIDTH-1:0]   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full     = (count == COUNT_TOP);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `WTWL_ASSERT_NOW(a_no_push_full, push, !full || pop, "request pushed into a full queue")
  `WTWL_ASSERT_NOW(a_no_pop_empty, pop, !empty, "request popped from an empty queue")
  `WTWL_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count lost a push")

endmodule
`default_nettype wire

// ----- hw/rtl/wtwl_back.sv -----
// Matcher: shifts characters into the window, compares with the pattern, holds the result.
`timescale 1ns / 1ps
`default_nettype none
`include "whitespace_tolerant_word_locator_assert.svh"
module wtwl_back #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [wtwl_pkg::PATTERN_W-1:0]    pattern_chars,
  input  wire logic [wtwl_pkg::LENGTH_W-1:0]     pattern_length,
  input  wire logic                              queue_empty,
  input  wire logic                              entry_clear,
  input  wire logic [wtwl_pkg::CHAR_W-1:0]       entry_char,
  input  wire logic [POSITION_BITS-1:0]          entry_line,
  input  wire logic [POSITION_BITS-1:0]          entry_column,
  output logic                                   pop,
  output logic                                   match_valid,
  input  wire logic                              match_stall,
  output logic [wtwl_pkg::RESULT_W-1:0]          match_line,
  output logic [wtwl_pkg::RESULT_W-1:0]          match_column,
  output logic [wtwl_pkg::RESULT_W-1:0]          match_total
);
  import wtwl_pkg::*;

  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam logic [FILL_W-1:0]   FILL_TOP  = FILL_W'(MAX_PATTERN);
  localparam logic [LENGTH_W-1:0] LEN_TOP   = LENGTH_W'(MAX_PATTERN);
  localparam logic [RESULT_W-1:0] COUNT_MAX = {RESULT_W{1'b1}};

  logic [CHAR_W-1:0]        win_char [MAX_PATTERN];
  logic [POSITION_BITS-1:0] win_line [MAX_PATTERN];
  logic [POSITION_BITS-1:0] win_col  [MAX_PATTERN];
  logic [FILL_W-1:0]        fill;
  logic [RESULT_W-1:0]      matches_seen;

  logic [CHAR_W-1:0]        nxt_char [MAX_PATTERN];
  logic [POSITION_BITS-1:0] nxt_line [MAX_PATTERN];
  logic [POSITION_BITS-1:0] nxt_col  [MAX_PATTERN];
  logic [FILL_W-1:0]        fill_next;
  logic [LENGTH_W-1:0]      len_used;
  logic [IDX_W-1:0]         len_idx;
  logic [MAX_PATTERN-1:0]   hit_by_len;
  logic                     hit;
  logic [RESULT_W-1:0]      total_next;

  assign pop = !queue_empty && (!match_valid || !match_stall);

  always_comb begin
    nxt_char[0] = entry_char;
    nxt_line[0] = entry_line;
    nxt_col[0]  = entry_column;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      nxt_char[i] = win_char[i-1];
      nxt_line[i] = win_line[i-1];
      nxt_col[i]  = win_col[i-1];
    end

    // A restart empties the window; stale entries beyond the fill are never compared.
    if (entry_clear) begin
      fill_next = FILL_W'(1);
    end else if (fill == FILL_TOP) begin
      fill_next = fill;
    end else begin
      fill_next = fill + 1'b1;
    end

    if (pattern_length == '0) begin
      len_used = LENGTH_W'(1);
    end else if (pattern_length > LEN_TOP) begin
      len_used = LEN_TOP;
    end else begin
      len_used = pattern_length;
    end
    len_idx = IDX_W'(len_used - LENGTH_W'(1));

    // One candidate per pattern length; the oldest character in use meets pattern byte 0.
    for (int l = 0; l < MAX_PATTERN; l++) begin
      hit_by_len[l] = 1'b1;
      for (int k = 0; k <= l; k++) begin
        if (nxt_char[l-k] != pattern_chars[CHAR_W*k +: CHAR_W]) begin
          hit_by_len[l] = 1'b0;
        end
      end
    end

    hit        = (LENGTH_W'(fill_next) >= len_used) && hit_by_len[len_idx];
    total_next = (matches_seen == COUNT_MAX) ? matches_seen : matches_seen + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_char[i] <= nxt_char[i];
        win_line[i] <= nxt_line[i];
        win_col[i]  <= nxt_col[i];
      end
    end
    if (pop && hit) begin
      match_line   <= RESULT_W'(nxt_line[len_idx]);
      match_column <= RESULT_W'(nxt_col[len_idx]);
      match_total  <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      matches_seen <= '0;
      match_valid  <= 1'b0;
    end else begin
      if (pop) begin
        fill <= fill_next;
      end
      if (pop && hit) begin
        matches_seen <= total_next;
        match_valid  <= 1'b1;
      end else if (match_valid && !match_stall) begin
        match_valid <= 1'b0;
      end
    end
  end

  `WTWL_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FILL_TOP, "window fill beyond its depth")
  `WTWL_ASSERT_NEXT(a_clear_fill, pop && entry_clear, fill == FILL_W'(1), "restart did not empty the window")
  `WTWL_ASSERT_NEXT(a_total_step, pop && hit, match_total == matches_seen, "reported total differs from the count")

endmodule
`default_nettype wire

// ----- hw/rtl/whitespace_tolerant_word_locator.sv -----
// Usage:
//   The text channel (text_valid, text_stall, text_byte, first_of_file) takes one byte
//   per request. A set first_of_file restarts line, column and window before the byte.
//   The match channel (match_valid, match_stall) delivers match_line, match_column
//   and match_total for every occurrence of the pattern, whitespace ignored.
//   The write port (cfg_we, cfg_index, cfg_data) loads pattern_chars (index 0) and
//   pattern_length (index 1); write it only while the block is idle.
// Timing:
//   One byte is taken every cycle while the queue has room. Given the queue was empty, a
//   match is presented once the completing byte has passed through the queue slot and the
//   window stage, whose output register holds the result. The matcher retires one queued
//   character per cycle while no stalled result is held, so the sustained rate is one
//   byte per clock, set by the single window compare stage.
//   A stalled result holds; the queue of QUEUE_DEPTH entries keeps taking bytes
//   until it fills, and text_stall then rises.
// Reset:
//   rst clears positions to line 1 column 1, empties the window and the queue,
//   zeroes the match count and loads a pattern length of 1.
`timescale 1ns / 1ps
`default_nettype none
module whitespace_tolerant_word_locator #(
  parameter int MAX_PATTERN   = wtwl_pkg::MAX_PATTERN_DEFAULT,
  parameter int POSITION_BITS = wtwl_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [wtwl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [wtwl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                text_valid,
  output logic                                     text_stall,
  input  wire logic [wtwl_pkg::CHAR_W-1:0]         text_byte,
  input  wire logic                                first_of_file,
  output logic                                     match_valid,
  input  wire logic                                match_stall,
  output logic [wtwl_pkg::RESULT_W-1:0]            match_line,
  output logic [wtwl_pkg::RESULT_W-1:0]            match_column,
  output logic [wtwl_pkg::RESULT_W-1:0]            match_total
);
  import wtwl_pkg::*;

  localparam int ENTRY_W = 1 + CHAR_W + 2 * POSITION_BITS;

  logic [PATTERN_W-1:0] pattern_chars;
  logic [LENGTH_W-1:0]  pattern_length;

  logic                     push, push_clear;
  logic [CHAR_W-1:0]        push_char;
  logic [POSITION_BITS-1:0] push_line, push_column;
  logic                     queue_full, queue_empty, pop;
  logic [ENTRY_W-1:0]       push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars  <= '0;
      pattern_length <= LENGTH_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_CHARS:  pattern_chars  <= cfg_data[PATTERN_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  wtwl_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .first_of_file(first_of_file),
    .queue_full   (queue_full),
    .push         (push),
    .push_clear   (push_clear),
    .push_char    (push_char),
    .push_line    (push_line),
    .push_column  (push_column)
  );

  assign push_data = {push_clear, push_char, push_line, push_column};

  wtwl_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  wtwl_back #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pattern_chars (pattern_chars),
    .pattern_length(pattern_length),
    .queue_empty   (queue_empty),
    .entry_clear   (pop_data[ENTRY_W-1]),
    .entry_char    (pop_data[2*POSITION_BITS +: CHAR_W]),
    .entry_line    (pop_data[POSITION_BITS +: POSITION_BITS]),
    .entry_column  (pop_data[0 +: POSITION_BITS]),
    .pop           (pop),
    .match_valid   (match_valid),
    .match_stall   (match_stall),
    .match_line    (match_line),
    .match_column  (match_column),
    .match_total   (match_total)
  );

endmodule
`default_nettype wire

// ----- tb/wtwl_match_checker.sv -----
`timescale 1ns / 1ps
// Match checker for the word locator: tracks the pattern registers, predicts and compares reports.
module wtwl_match_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wtwl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wtwl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             text_valid,
  input  logic                             text_stall,
  input  logic [wtwl_pkg::CHAR_W-1:0]      text_byte,
  input  logic                             first_of_file,
  input  logic                             match_valid,
  input  logic                             match_stall,
  input  logic [wtwl_pkg::RESULT_W-1:0]    match_line,
  input  logic [wtwl_pkg::RESULT_W-1:0]    match_column,
  input  logic [wtwl_pkg::RESULT_W-1:0]    match_total,
  output int                               fault_count,
  output int                               reports_awaited
);
  import wtwl_pkg::*;

  localparam int WINDOW = MAX_PATTERN_DEFAULT;
  localparam logic [RESULT_W-1:0] SAT_TOP = '1;
  localparam logic [RESULT_W-1:0] POS_ONE = RESULT_W'(1);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [RESULT_W-1:0] line;
    logic [RESULT_W-1:0] column;
    logic [RESULT_W-1:0] total;
  } match_report_t;

  logic [PATTERN_W-1:0] pattern_q = '0;
  logic [LENGTH_W-1:0]  length_q = 4'd1;
  logic [CHAR_W-1:0]    win_char [WINDOW];
  logic [RESULT_W-1:0]  win_line [WINDOW];
  logic [RESULT_W-1:0]  win_col [WINDOW];
  int                   win_fill;
  logic [RESULT_W-1:0]  line_now;
  logic [RESULT_W-1:0]  col_now;
  logic [RESULT_W-1:0]  total_now;
  int                   faults = 0;
  match_report_t        reports_due [$];

  initial begin
    fault_count = 0;
    reports_awaited = 0;
  end

  function automatic logic [RESULT_W-1:0] bump(input logic [RESULT_W-1:0] v);
    return (v == SAT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic void restart_position();
    for (int i = 0; i < WINDOW; i++) begin
      win_char[i] = '0;
      win_line[i] = '0;
      win_col[i] = '0;
    end
    win_fill = 0;
    line_now = POS_ONE;
    col_now = POS_ONE;
  endfunction

  // Works out the report, if any, that one accepted text request causes.
  function automatic void locate(input logic [CHAR_W-1:0] c, input logic restart);
    int span;
    logic hit;
    match_report_t rep;
    if (restart) restart_position();
    if (c == CH_LF) begin
      line_now = bump(line_now);
      col_now = POS_ONE;
      return;
    end
    if (c == CH_TAB || c == CH_SPACE) begin
      col_now = bump(col_now);
      return;
    end
    for (int i = WINDOW - 1; i > 0; i--) begin
      win_char[i] = win_char[i-1];
      win_line[i] = win_line[i-1];
      win_col[i] = win_col[i-1];
    end
    win_char[0] = c;
    win_line[0] = line_now;
    win_col[0] = col_now;
    if (win_fill < WINDOW) win_fill++;
    col_now = bump(col_now);
    // A length of zero acts as one, and anything past the window as the full window.
    if (length_q == 0) span = 1;
    else if (length_q > WINDOW) span = WINDOW;
    else span = int'(length_q);
    if (win_fill < span) return;
    hit = 1'b1;
    for (int k = 0; k < span; k++) begin
      if (win_char[span-1-k] != pattern_q[8*k +: 8]) hit = 1'b0;
    end
    if (!hit) return;
    if (total_now != SAT_TOP) total_now++;
    rep.line = win_line[span-1];
    rep.column = win_col[span-1];
    rep.total = total_now;
    reports_due.push_back(rep);
  endfunction

  always @(posedge clk) begin
    match_report_t want;
    if (rst) begin
      restart_position();
      total_now = '0;
      pattern_q = '0;
      length_q = 4'd1;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_CHARS: pattern_q = cfg_data;
          REG_PATTERN_LENGTH: length_q = cfg_data[LENGTH_W-1:0];
          default: ;
        endcase
      end
      if (match_valid && !match_stall) begin
        if (reports_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("%0t: report with none outstanding: line %0d column %0d total %0d",
                     $time, match_line, match_column, match_total);
        end else begin
          want = reports_due.pop_front();
          if (want.line !== match_line || want.column !== match_column ||
              want.total !== match_total) begin
            faults++;
            if (faults <= REPORT_LIMIT)
              $display("%0t: report wrong: expected line %0d column %0d total %0d, got %0d %0d %0d",
                       $time, want.line, want.column, want.total,
                       match_line, match_column, match_total);
          end
        end
      end
      if (text_valid && !text_stall) locate(text_byte, first_of_file);
    end
    fault_count <= faults;
    reports_awaited <= reports_due.size();
  end

endmodule

// ----- tb/whitespace_tolerant_word_locator_test.sv -----
`timescale 1ns / 1ps
// Top of the word locator testbench: clock, reset, text and register stimulus, and the verdict.
module whitespace_tolerant_word_locator_test;
  import wtwl_pkg::*;

  localparam int LIMIT_CYCLES = 1_200_000;
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_REQUESTS = 256;
  localparam int IDLE_PCT = 8;
  localparam int RESTART_PCT = 2;
  localparam logic [CHAR_W-1:0] CH_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_B = 8'h62;
  localparam logic [CHAR_W-1:0] CH_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_Y = 8'h79;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   text_valid = 1'b0;
  logic [CHAR_W-1:0]      text_byte = '0;
  logic                   first_of_file = 1'b0;
  logic                   match_stall = 1'b0;
  wire                    text_stall;
  wire                    match_valid;
  wire [RESULT_W-1:0]     match_line;
  wire [RESULT_W-1:0]     match_column;
  wire [RESULT_W-1:0]     match_total;
  int                     fault_count;
  int                     reports_awaited;

  logic                   calm = 1'b0;
  int                     hold_asks = 0;
  int                     hold_seen = 0;
  int                     hold_left = 0;
  logic [PATTERN_W-1:0]   pat_now = '0;
  int                     span_now = 1;
  int                     sent = 0;

  whitespace_tolerant_word_locator uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .text_valid(text_valid), .text_stall(text_stall),
    .text_byte(text_byte), .first_of_file(first_of_file),
    .match_valid(match_valid), .match_stall(match_stall),
    .match_line(match_line), .match_column(match_column), .match_total(match_total)
  );

  wtwl_match_checker match_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .text_valid(text_valid), .text_stall(text_stall),
    .text_byte(text_byte), .first_of_file(first_of_file),
    .match_valid(match_valid), .match_stall(match_stall),
    .match_line(match_line), .match_column(match_column), .match_total(match_total),
    .fault_count(fault_count), .reports_awaited(reports_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Report side: a fresh ask from the stimulus starts a long hold-off, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      match_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      match_stall <= 1'b1;
    end else begin
      match_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic logic coin(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [CHAR_W-1:0] blank_byte();
    case ($urandom_range(2))
      0: return CH_TAB;
      1: return CH_LF;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] noise_byte();
    logic [CHAR_W-1:0] b;
    b = CHAR_W'($urandom_range(255));
    return coin(50) ? blank_byte() : b;
  endfunction

  function automatic logic [PATTERN_W-1:0] random_pattern(input logic two_letters);
    logic [PATTERN_W-1:0] p;
    logic [CHAR_W-1:0] b;
    for (int k = 0; k < 8; k++) begin
      if (two_letters) begin
        b = coin(50) ? CH_A : CH_B;
      end else begin
        do b = CHAR_W'($urandom_range(255)); while (b == CH_TAB || b == CH_LF || b == CH_SPACE);
      end
      p[8*k +: 8] = b;
    end
    return p;
  endfunction

  // One text request; the payload holds until the block takes it.
  task automatic offer_byte(input logic [CHAR_W-1:0] b, input logic restart);
    if (!calm && coin(IDLE_PCT)) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte <= b;
    first_of_file <= restart;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    sent++;
  endtask

  // Waits for every outstanding report, then lets queued characters without a match drain.
  task automatic settle();
    text_valid <= 1'b0;
    do @(posedge clk); while (reports_awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pattern(input logic [PATTERN_W-1:0] chars, input int len);
    write_register(REG_PATTERN_CHARS, chars);
    write_register(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    pat_now = chars;
    span_now = (len == 0) ? 1 : (len > MAX_PATTERN_DEFAULT ? MAX_PATTERN_DEFAULT : len);
  endtask

  // Mostly whole patterns with blanks between the letters, and less often cut-off ones and noise.
  task automatic run_phase(input int count);
    int stop_at;
    int pick;
    int cut;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        for (int k = 0; k < span_now; k++) begin
          if (k != 0 && coin(30)) offer_byte(blank_byte(), coin(RESTART_PCT));
          offer_byte(pat_now[8*k +: 8], coin(RESTART_PCT));
        end
      end else if (pick < 75) begin
        cut = $urandom_range(span_now - 1, 0);
        for (int k = 0; k < cut; k++) offer_byte(pat_now[8*k +: 8], coin(RESTART_PCT));
        offer_byte(noise_byte(), coin(RESTART_PCT));
      end else begin
        repeat ($urandom_range(4, 1)) offer_byte(noise_byte(), coin(RESTART_PCT));
      end
    end
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset pattern is a single NUL; carriage return is an ordinary character.
    offer_byte(8'h00, 1'b0);
    offer_byte(CH_CR, 1'b0);

    // Overlapping matches across blanks, with a restart on the first request.
    set_pattern({40'hFF_FFFF_FFFF, CH_A, CH_B, CH_A}, 3);
    offer_byte(CH_A, 1'b1);
    offer_byte(CH_SPACE, 1'b0);
    offer_byte(CH_B, 1'b0);
    offer_byte(CH_LF, 1'b0);
    offer_byte(CH_TAB, 1'b0);
    offer_byte(CH_A, 1'b0);
    offer_byte(CH_B, 1'b0);
    offer_byte(CH_A, 1'b0);

    // A zero length behaves as one.
    write_register(REG_PATTERN_LENGTH, '0);
    span_now = 1;
    offer_byte(CH_A, 1'b0);
    offer_byte(CH_B, 1'b0);

    // An overlong length uses the whole window.
    set_pattern('1, 15);
    repeat (9) offer_byte(8'hFF, 1'b0);

    // A blank in the pattern can never be matched.
    set_pattern({56'd0, CH_SPACE}, 1);
    offer_byte(CH_SPACE, 1'b0);
    offer_byte(8'h00, 1'b0);

    calm <= 1'b1;
    set_pattern(random_pattern(1'b0), 3);
    run_phase(PHASE_REQUESTS);
    calm <= 1'b0;

    set_pattern(random_pattern(1'b0), 8);
    hold_asks <= hold_asks + 1;
    run_phase(PHASE_REQUESTS);

    set_pattern(random_pattern(1'b0), 1);
    run_phase(PHASE_REQUESTS);
    set_pattern(random_pattern(1'b0), 0);
    run_phase(PHASE_REQUESTS / 2);
    set_pattern(random_pattern(1'b0), 15);
    run_phase(PHASE_REQUESTS);
    set_pattern('1, 4);
    run_phase(PHASE_REQUESTS / 2);
    set_pattern('0, 2);
    run_phase(PHASE_REQUESTS / 2);
    set_pattern(random_pattern(1'b1), $urandom_range(8, 1));
    run_phase(PHASE_REQUESTS);
    set_pattern(random_pattern(1'b1), $urandom_range(8, 1));
    run_phase(PHASE_REQUESTS / 2);
    set_pattern({40'hFF_FFFF_FFFF, CH_Y, CH_TAB, CH_X}, 3);
    run_phase(PHASE_REQUESTS / 2);

    settle();
    if (fault_count == 0 && reports_awaited == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
